// ===== hw/rtl/gb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 Gaussian blur unit.
package gb3_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned MaxHeight   = 1024;
  localparam int unsigned NumChannels = 3;
  localparam int unsigned LaneCount   = 3;
  localparam int unsigned PixW        = 8;
  localparam int unsigned AddrW       = $clog2(MaxWidth);
  localparam int unsigned SizeW       = 11;
  localparam int unsigned WeightW     = 12;
  localparam int unsigned FracW       = 12;
  localparam int unsigned CoordW      = 10;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned NumCells    = 2;
  localparam int unsigned OfifoDepth  = 8;
  localparam int unsigned OfifoPtrW   = $clog2(OfifoDepth);
  localparam int unsigned OfifoCntW   = $clog2(OfifoDepth + 1);

  // Reset values: normalized sigma 1.3 kernel in Q0.12
  localparam logic [SizeW-1:0]   ResetWidth  = SizeW'(640);
  localparam logic [SizeW-1:0]   ResetHeight = SizeW'(480);
  localparam logic [WeightW-1:0] ResetCenter = WeightW'(662);
  localparam logic [WeightW-1:0] ResetSide   = WeightW'(492);
  localparam logic [WeightW-1:0] ResetCorner = WeightW'(366);

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth,
    CfgImageHeight,
    CfgWeightCenter,
    CfgWeightSide,
    CfgWeightCorner
  } gb3_cfg_e;

  typedef enum logic {
    CmdPixel,
    CmdPad
  } gb3_cmd_e;

  typedef logic [LaneCount-1:0][PixW-1:0] gb3_pix_t;
  typedef logic [8:0][PixW-1:0] gb3_tap9_t;

  typedef struct packed {
    gb3_pix_t top;
    gb3_pix_t mid;
    gb3_pix_t bot;
  } gb3_col_t;

  typedef struct packed {
    gb3_pix_t upper;
    gb3_pix_t middle;
  } gb3_line_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } gb3_cell_ctl_t;

  typedef struct packed {
    logic load_sums;
    logic load_prods;
  } gb3_chan_ctl_t;

  typedef struct packed {
    logic [WeightW-1:0] center;
    logic [WeightW-1:0] side;
    logic [WeightW-1:0] corner;
  } gb3_weights_t;

  typedef struct packed {
    gb3_cmd_e          command;
    logic [PixW-1:0]   in_red;
    logic [PixW-1:0]   in_green;
    logic [PixW-1:0]   in_blue;
  } gb3_in_t;

  typedef struct packed {
    logic [PixW-1:0]   out_red;
    logic [PixW-1:0]   out_green;
    logic [PixW-1:0]   out_blue;
    logic [CoordW-1:0] out_column;
    logic [CoordW-1:0] out_row;
    logic              frame_done;
  } gb3_out_t;

endpackage

// ===== hw/rtl/gaussian_blur_3x3_unit.sv =====
`timescale 1ns / 1ps
// Top level of the 3x3 Gaussian blur unit for RGB raster streams.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one item per raster
//   position, pixel or padding tick. After each frame send image_width+1
//   padding ticks to flush the last row and column.
//   Output channel (out_valid_o/out_ready_i/out_data_o): filtered pixel with
//   its row/column; frame_done marks the last pixel of the frame.
//   Config channel (cfg_valid_i/cfg_ready_o): always ready; write only while
//   the unit is idle. Index order: width, height, center, side, corner weight.
// Pipeline: a result caused by an accepted item passes the stage 1 registers,
//   the sum and product registers and the output queue. Pixel (r,c) comes with
//   the item at (r+1,c+1), or with the item at (r+2,0) for the last column.
// Throughput: one item per clock while in_ready_o is high. The line store RAM
//   is read at accept and written next cycle, once per item; hence the rate.
// Stalls: an 8-entry output queue holds results; in_ready_o drops only when
//   8 results are in flight or queued and not yet taken.
// Reset: position, window and queue clear at once; line stores are not
//   cleared (rows above the image are masked by the row count).
module gaussian_blur_3x3_unit import gb3_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gb3_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gb3_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WeightW-1:0] cfg_data_i
);

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                   input logic [SizeW-1:0] maxv);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  logic [SizeW-1:0] width_q, height_q;
  gb3_weights_t     weights_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q          <= ResetWidth;
      height_q         <= ResetHeight;
      weights_q.center <= ResetCenter;
      weights_q.side   <= ResetSide;
      weights_q.corner <= ResetCorner;
    end else if (cfg_valid_i) begin
      unique case (gb3_cfg_e'(cfg_index_i))
        CfgImageWidth:   width_q  <= clamp_size(cfg_data_i[SizeW-1:0], SizeW'(MaxWidth));
        CfgImageHeight:  height_q <= clamp_size(cfg_data_i[SizeW-1:0], SizeW'(MaxHeight));
        CfgWeightCenter: weights_q.center <= cfg_data_i;
        CfgWeightSide:   weights_q.side   <= cfg_data_i;
        CfgWeightCorner: weights_q.corner <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: position tracking, emit decision ----------------
  logic [AddrW-1:0]  col_q, col_d;
  logic [SizeW-1:0]  row_q, row_d;
  logic [SizeW-1:0]  col_ext, col_inc, col_m1, row_m1, row_m2, w_m1, h_m1;
  logic [SizeW-1:0]  orow_s0, ocol_s0;
  logic              col_zero, row_ge1, row_ge2, emit_a, emit_b, emit_s0, done_s0;
  logic              frame_end, pixel_ok, in_fire;
  gb3_pix_t          in_lanes, sample_s0;
  logic [OfifoCntW-1:0] used_q, used_d;

  assign in_ready_o = (used_q < OfifoCntW'(OfifoDepth));
  assign in_fire    = in_valid_i && in_ready_o;

  assign col_ext  = SizeW'(col_q);
  assign col_inc  = col_ext + SizeW'(1);
  assign col_m1   = col_ext - SizeW'(1);
  assign row_m1   = row_q - SizeW'(1);
  assign row_m2   = row_q - SizeW'(2);
  assign w_m1     = width_q - SizeW'(1);
  assign h_m1     = height_q - SizeW'(1);
  assign col_zero = (col_q == '0);
  assign row_ge1  = (row_q != '0);
  assign row_ge2  = (row_q >= SizeW'(2));

  // Column zero flushes the last pixel of the row two back; otherwise the pixel
  // one row up and one column left is finished.
  assign emit_a  = col_zero && row_ge2 && (row_m2 < height_q);
  assign emit_b  = !col_zero && row_ge1 && (row_m1 < height_q) && (col_m1 < width_q);
  assign emit_s0 = emit_a || emit_b;
  assign orow_s0 = col_zero ? row_m2 : row_m1;
  assign ocol_s0 = col_zero ? w_m1 : col_m1;
  assign done_s0 = (orow_s0 == h_m1) && (ocol_s0 == w_m1);

  assign frame_end = ({1'b0, row_q} >= ({1'b0, height_q} + (SizeW + 1)'(1)));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= width_q) begin
      col_d = '0;
      row_d = row_q + SizeW'(1);
    end else begin
      col_d = AddrW'(col_inc);
    end
  end

  // Pixels below the image and padding ticks enter as zero
  assign pixel_ok = (in_data_i.command == CmdPixel) && (row_q < height_q);
  assign in_lanes = {in_data_i.in_blue, in_data_i.in_green, in_data_i.in_red};

  always_comb begin
    for (int c = 0; c < LaneCount; c++) begin
      sample_s0[c] = (pixel_ok && (c < NumChannels)) ? in_lanes[c] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      used_q <= '0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      used_q <= used_d;
    end
  end

  // Credits: every accepted item that will produce a result holds a queue slot
  assign used_d = used_q + OfifoCntW'(in_fire && emit_s0)
                         - OfifoCntW'(out_valid_o && out_ready_i);

  // ---------------- stage 1: line store read, window update ----------------
  logic               s1_valid_q, s1_emit_q, s1_ge1_q, s1_ge2_q, s1_czero_q, s1_done_q;
  logic [AddrW-1:0]   s1_addr_q;
  gb3_pix_t           s1_sample_q;
  logic [CoordW-1:0]  s1_ocol_q, s1_orow_q;
  logic               fwd_hit_q, fwd_hit_d;
  gb3_line_t          fwd_line_q;
  gb3_line_t          ram_rdata, rd_line, wr_line;
  gb3_col_t           new_col, right_col;
  gb3_col_t           cell_in  [NumCells];
  gb3_col_t           cell_out [NumCells];
  gb3_cell_ctl_t      cell_ctl [NumCells];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      fwd_hit_q  <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_emit_q   <= emit_s0;
      s1_ge1_q    <= row_ge1;
      s1_ge2_q    <= row_ge2;
      s1_czero_q  <= col_zero;
      s1_done_q   <= done_s0;
      s1_addr_q   <= col_q;
      s1_sample_q <= sample_s0;
      s1_ocol_q   <= ocol_s0[CoordW-1:0];
      s1_orow_q   <= orow_s0[CoordW-1:0];
    end
    fwd_line_q <= wr_line;
  end

  // Same column read while it is being written (width of one): forward
  assign fwd_hit_d = in_fire && s1_valid_q && (s1_addr_q == col_q);
  assign rd_line   = fwd_hit_q ? fwd_line_q : ram_rdata;

  assign new_col.top = s1_ge2_q ? rd_line.upper : '0;
  assign new_col.mid = s1_ge1_q ? rd_line.middle : '0;
  assign new_col.bot = s1_sample_q;

  assign wr_line.upper  = rd_line.middle;
  assign wr_line.middle = s1_sample_q;

  gb3_ram #(
    .Width ($bits(gb3_line_t)),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_line),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // Window chain: the cells hold the two newest columns; the incoming column
  // completes the 3x3 view. Column zero starts a row with a zero left column.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    if (i == NumCells - 1) begin : g_last
      assign cell_in[i]        = new_col;
      assign cell_ctl[i].clear = 1'b0;
    end else begin : g_mid
      assign cell_in[i]        = cell_out[i+1];
      assign cell_ctl[i].clear = s1_czero_q;
    end
    assign cell_ctl[i].shift = s1_valid_q;

    gb3_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl[i]),
      .col_i  (cell_in[i]),
      .col_o  (cell_out[i])
    );
  end

  assign right_col = s1_czero_q ? '0 : new_col;

  // ---------------- stages 2/3: kernel arithmetic ----------------
  logic              s2_valid_q, s3_valid_q;
  logic [CoordW-1:0] s2_ocol_q, s2_orow_q, s3_ocol_q, s3_orow_q;
  logic              s2_done_q, s3_done_q;
  gb3_chan_ctl_t     chan_ctl;
  gb3_tap9_t         taps [LaneCount];
  logic [PixW-1:0]   lane_val [LaneCount];
  gb3_out_t          res;

  assign chan_ctl.load_sums  = s1_valid_q && s1_emit_q;
  assign chan_ctl.load_prods = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= chan_ctl.load_sums;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chan_ctl.load_sums) begin
      s2_ocol_q <= s1_ocol_q;
      s2_orow_q <= s1_orow_q;
      s2_done_q <= s1_done_q;
    end
    if (s2_valid_q) begin
      s3_ocol_q <= s2_ocol_q;
      s3_orow_q <= s2_orow_q;
      s3_done_q <= s2_done_q;
    end
  end

  for (genvar c = 0; c < LaneCount; c++) begin : g_lane
    // taps in window order: row-major, left column first
    assign taps[c] = {right_col.bot[c],       cell_out[NumCells-1].bot[c], cell_out[0].bot[c],
                      right_col.mid[c],       cell_out[NumCells-1].mid[c], cell_out[0].mid[c],
                      right_col.top[c],       cell_out[NumCells-1].top[c], cell_out[0].top[c]};
    if (c < NumChannels) begin : g_on
      gb3_chan u_chan (
        .clk_i     (clk_i),
        .ctl_i     (chan_ctl),
        .taps_i    (taps[c]),
        .weights_i (weights_q),
        .value_o   (lane_val[c])
      );
    end else begin : g_off
      assign lane_val[c] = '0;
    end
  end

  assign res.out_red    = lane_val[0];
  assign res.out_green  = lane_val[1];
  assign res.out_blue   = lane_val[2];
  assign res.out_column = s3_ocol_q;
  assign res.out_row    = s3_orow_q;
  assign res.frame_done = s3_done_q;

  gb3_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/gb3_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, registered read, old data on collision.
module gb3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gb3_cell.sv =====
`timescale 1ns / 1ps
// One window column cell: holds three pixels, loads from its right neighbor.
module gb3_cell import gb3_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gb3_cell_ctl_t ctl_i,
  input  gb3_col_t      col_i,
  output gb3_col_t      col_o
);

  gb3_col_t col_q, col_d;

  always_comb begin
    col_d = col_q;
    if (ctl_i.shift) begin
      col_d = ctl_i.clear ? '0 : col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hw/rtl/gb3_chan.sv =====
`timescale 1ns / 1ps
// Per-channel kernel datapath: tap sums, weight products, truncate and saturate.
module gb3_chan import gb3_pkg::*; (
  input  logic            clk_i,
  input  gb3_chan_ctl_t   ctl_i,
  input  gb3_tap9_t       taps_i,
  input  gb3_weights_t    weights_i,
  output logic [PixW-1:0] value_o
);

  localparam int unsigned SumW  = PixW + 2;
  localparam int unsigned CProdW = PixW + WeightW;
  localparam int unsigned SProdW = SumW + WeightW;
  localparam int unsigned AccW  = PixW + WeightW + 4;

  logic [PixW-1:0]   center_q;
  logic [SumW-1:0]   side_d, side_q, diag_d, diag_q;
  logic [CProdW-1:0] pc_q;
  logic [SProdW-1:0] ps_q, pd_q;
  logic [AccW-1:0]   acc;
  logic [AccW-FracW-1:0] scaled;

  // side taps: 1,3,5,7; diagonal taps: 0,2,6,8
  assign side_d = SumW'(taps_i[1]) + SumW'(taps_i[3]) + SumW'(taps_i[5]) + SumW'(taps_i[7]);
  assign diag_d = SumW'(taps_i[0]) + SumW'(taps_i[2]) + SumW'(taps_i[6]) + SumW'(taps_i[8]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_sums) begin
      center_q <= taps_i[4];
      side_q   <= side_d;
      diag_q   <= diag_d;
    end
    if (ctl_i.load_prods) begin
      pc_q <= CProdW'(weights_i.center) * CProdW'(center_q);
      ps_q <= SProdW'(weights_i.side) * SProdW'(side_q);
      pd_q <= SProdW'(weights_i.corner) * SProdW'(diag_q);
    end
  end

  assign acc     = AccW'(pc_q) + AccW'(ps_q) + AccW'(pd_q);
  assign scaled  = acc[AccW-1:FracW];
  assign value_o = (|scaled[AccW-FracW-1:PixW]) ? {PixW{1'b1}} : scaled[PixW-1:0];

endmodule

// ===== hw/rtl/gb3_ofifo.sv =====
`timescale 1ns / 1ps
// Output queue for finished result items.
module gb3_ofifo import gb3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  gb3_out_t push_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gb3_out_t out_data_o
);

  gb3_out_t             mem_q [OfifoDepth];
  logic [OfifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OfifoCntW-1:0] count_q, count_d;
  logic                 pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OfifoPtrW'(OfifoDepth - 1)) ? '0 : wr_ptr_q + OfifoPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == OfifoPtrW'(OfifoDepth - 1)) ? '0 : rd_ptr_q + OfifoPtrW'(1);
    end
    count_d = count_q + OfifoCntW'(push_i) - OfifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== test/gb3_blur_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the 3x3 Gaussian blur unit: watches all channels, predicts and compares.
module gb3_blur_checker import gb3_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  gb3_in_t            in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  gb3_out_t           out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WeightW-1:0] cfg_data_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o,
  output int unsigned        result_count_o
);

  logic [SizeW-1:0] width_reg;
  logic [SizeW-1:0] height_reg;
  gb3_weights_t     weights;
  gb3_line_t        line_mem [MaxWidth];
  gb3_pix_t         win [9];
  int unsigned      pos_col;
  int unsigned      pos_row;
  gb3_out_t         expected_pixels [$];
  int unsigned      pending;
  int unsigned      failures;
  int unsigned      results_seen;

  assign pending_o      = pending;
  assign fail_count_o   = failures;
  assign result_count_o = results_seen;

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic shift_window(input gb3_pix_t top, input gb3_pix_t mid, input gb3_pix_t bot);
    gb3_pix_t fresh [3];
    fresh[0] = top;
    fresh[1] = mid;
    fresh[2] = bot;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
      win[r*3+2] = fresh[r];
    end
  endtask

  // Weighted 3x3 sum per lane, Q0.12 truncated, clipped to 8 bits
  function automatic gb3_out_t blur_pixel(input int unsigned orow, input int unsigned ocol,
                                          input int unsigned w, input int unsigned h);
    gb3_out_t        px;
    int unsigned     acc;
    logic [PixW-1:0] lanes [LaneCount];
    for (int c = 0; c < LaneCount; c++) begin
      acc = 0;
      if (c < NumChannels) begin
        acc = weights.center * win[4][c]
            + weights.side * (win[1][c] + win[3][c] + win[5][c] + win[7][c])
            + weights.corner * (win[0][c] + win[2][c] + win[6][c] + win[8][c]);
        acc = acc >> FracW;
        if (acc > 255) acc = 255;
      end
      lanes[c] = PixW'(acc);
    end
    px.out_red    = lanes[0];
    px.out_green  = lanes[1];
    px.out_blue   = lanes[2];
    px.out_column = CoordW'(ocol);
    px.out_row    = CoordW'(orow);
    px.frame_done = (orow == h - 1) && (ocol == w - 1);
    return px;
  endfunction

  task automatic predict_blur(input gb3_in_t item);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    gb3_pix_t    sample;
    gb3_pix_t    up;
    gb3_pix_t    mid;
    w      = clamp_size(width_reg, MaxWidth);
    h      = clamp_size(height_reg, MaxHeight);
    idx    = (pos_col < MaxWidth) ? pos_col : 0;
    sample = '0;
    // pad ticks and anything below the image enter as black
    if (item.command == CmdPixel && pos_row < h) begin
      sample = {item.in_blue, item.in_green, item.in_red};
    end
    // row start: flush the right border pixel of the row two back
    if (pos_col == 0) begin
      shift_window('0, '0, '0);
      if (pos_row >= 2 && pos_row - 2 < h) begin
        expected_pixels.push_back(blur_pixel(pos_row - 2, w - 1, w, h));
      end
      foreach (win[k]) win[k] = '0;
    end
    up  = (pos_row >= 2) ? line_mem[idx].upper : '0;
    mid = (pos_row >= 1) ? line_mem[idx].middle : '0;
    line_mem[idx].upper  = line_mem[idx].middle;
    line_mem[idx].middle = sample;
    shift_window(up, mid, sample);
    if (pos_col >= 1 && pos_row >= 1 && pos_row - 1 < h && pos_col - 1 < w) begin
      expected_pixels.push_back(blur_pixel(pos_row - 1, pos_col - 1, w, h));
    end
    if (pos_row >= h + 1) begin
      pos_col = 0;
      pos_row = 0;
    end else if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row++;
    end else begin
      pos_col++;
    end
  endtask

  function automatic string pixel_text(input gb3_out_t p);
    return $sformatf("rgb=(%0d,%0d,%0d) row=%0d col=%0d done=%0d", p.out_red, p.out_green,
                     p.out_blue, p.out_row, p.out_column, p.frame_done);
  endfunction

  task automatic check_pixel(input gb3_out_t got);
    gb3_out_t want;
    results_seen++;
    if (expected_pixels.size() == 0) begin
      failures++;
      $display("%0t: unexpected output, expected none, got %s", $time, pixel_text(got));
    end else begin
      want = expected_pixels.pop_front();
      if (got !== want) begin
        failures++;
        $display("%0t: output mismatch, expected %s, got %s", $time, pixel_text(want),
                 pixel_text(got));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg      = ResetWidth;
      height_reg     = ResetHeight;
      weights.center = ResetCenter;
      weights.side   = ResetSide;
      weights.corner = ResetCorner;
      foreach (line_mem[k]) line_mem[k] = '0;
      foreach (win[k]) win[k] = '0;
      pos_col = 0;
      pos_row = 0;
      expected_pixels.delete();
      pending      = 0;
      failures     = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (gb3_cfg_e'(cfg_index_i))
          CfgImageWidth:   width_reg = cfg_data_i[SizeW-1:0];
          CfgImageHeight:  height_reg = cfg_data_i[SizeW-1:0];
          CfgWeightCenter: weights.center = cfg_data_i;
          CfgWeightSide:   weights.side = cfg_data_i;
          CfgWeightCorner: weights.corner = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_blur(in_data_i);
      if (out_valid_i && out_ready_i) check_pixel(out_data_i);
      pending = expected_pixels.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the blur unit testbench: clock, reset, stimulus, output sink and verdict.
module testbench;
  import gb3_pkg::*;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned MaxGap       = 8;
  // an item that makes no pixel may still be in the pipe when the queue runs dry
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned RandomItems  = 850;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned EndWaitLimit = 20000;
  // byte patterns for the directed frames: all ones, all zeros, both checkerboards
  localparam logic [31:0] EdgeSamples  = 32'h55AA_00FF;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid;
  logic           in_ready;
  gb3_in_t        in_data;
  logic           out_valid;
  logic           out_ready;
  gb3_out_t       out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  gb3_cfg_e       cfg_index;
  logic [WeightW-1:0] cfg_data;

  int unsigned    pending;
  int unsigned    failures;
  int unsigned    results_checked;

  // stimulus bookkeeping: register shadow, raster position, pacing knobs
  logic [WeightW-1:0] reg_vals [5];
  logic [WeightW-1:0] next_vals [5];
  int unsigned    pos_col = 0;
  int unsigned    pos_row = 0;
  int unsigned    src_gap_max = MaxGap;
  int unsigned    sink_gap_max = MaxGap;
  bit             sink_hold_req = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    frames_done = 0;
  int unsigned    reg_writes = 0;
  int unsigned    cycles = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  gaussian_blur_3x3_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gb3_blur_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .fail_count_o   (failures),
    .result_count_o (results_checked)
  );

  // Watchdog: the slowest legal run is far below this bound.
  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= CycleLimit);
    $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
    $display("gaussian_blur_3x3_unit test failed");
    $finish;
  end

  // Output sink: random back-pressure per item, one long hold on request.
  // The hold is counted here so the source keeps offering items meanwhile.
  initial begin : pixel_sink
    int unsigned hold;
    out_ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_req) begin
        hold = LongHold;
        sink_hold_req = 1'b0;
      end else begin
        hold = $urandom_range(0, sink_gap_max);
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [PixW-1:0] random_sample();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // Mirror of the unit's raster counter, so frames can be cut and finished.
  task automatic advance_position();
    int unsigned w;
    int unsigned h;
    w = clamp_size(reg_vals[CfgImageWidth][SizeW-1:0], MaxWidth);
    h = clamp_size(reg_vals[CfgImageHeight][SizeW-1:0], MaxHeight);
    if (pos_row >= h + 1) begin
      pos_col = 0;
      pos_row = 0;
    end else if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row++;
    end else begin
      pos_col++;
    end
  endtask

  // Writes the registers picked by sel from next_vals, in index order.
  // Valid stays high across back-to-back writes and drops once at the end.
  task automatic configure(input logic [4:0] sel);
    for (int i = 0; i < 5; i++) begin
      if (sel[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= gb3_cfg_e'(i);
        cfg_data  <= next_vals[i];
        do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
        reg_vals[i] = next_vals[i];
        reg_writes++;
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input gb3_in_t item);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    items_sent++;
    advance_position();
  endtask

  // Streams ticks until the raster wraps back to the frame start, or until
  // stop_after items when a frame is to be cut for a mid-frame height change.
  // Inside the image mostly pixels with the odd pad tick; below it mostly pad
  // ticks with the odd pixel command, which the unit must treat as black.
  task automatic run_frame(input int unsigned stop_after, input bit directed);
    int unsigned h;
    int unsigned k;
    gb3_in_t     item;
    h = clamp_size(reg_vals[CfgImageHeight][SizeW-1:0], MaxHeight);
    k = 0;
    do begin
      if (directed) begin
        if (pos_row < h) item.command = (k == 4) ? CmdPad : CmdPixel;
        else item.command = (pos_col == 0) ? CmdPixel : CmdPad;
        item.in_red   = EdgeSamples[8*(k % 4) +: 8];
        item.in_green = EdgeSamples[8*((k + 1) % 4) +: 8];
        item.in_blue  = EdgeSamples[8*((k + 2) % 4) +: 8];
      end else begin
        if (pos_row < h) item.command = ($urandom_range(0, 9) == 0) ? CmdPad : CmdPixel;
        else item.command = ($urandom_range(0, 6) == 0) ? CmdPixel : CmdPad;
        item.in_red   = random_sample();
        item.in_green = random_sample();
        item.in_blue  = random_sample();
      end
      send_item(item);
      k++;
    end while (!(pos_col == 0 && pos_row == 0) && k != stop_after);
    if (pos_col == 0 && pos_row == 0) frames_done++;
  endtask

  // Source pause: hold input until every predicted pixel is out, then let
  // any result-free items clear the pipe before the registers change.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [WeightW-1:0] random_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return WeightW'($urandom_range(0, 4095));
      default: return WeightW'($urandom_range(0, 700));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_start;
    int unsigned frame_len;
    int unsigned w;
    int unsigned h;
    int unsigned waited;
    logic [4:0]  sel;

    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CfgImageWidth;
    cfg_data  <= '0;
    reg_vals[CfgImageWidth]   = WeightW'(ResetWidth);
    reg_vals[CfgImageHeight]  = WeightW'(ResetHeight);
    reg_vals[CfgWeightCenter] = ResetCenter;
    reg_vals[CfgWeightSide]   = ResetSide;
    reg_vals[CfgWeightCorner] = ResetCorner;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 3x3 frame on the reset kernel, with a pad tick at the center
    // pixel and pixel commands in the flush rows.
    next_vals = reg_vals;
    next_vals[CfgImageWidth]  = 3;
    next_vals[CfgImageHeight] = 3;
    configure(5'b00011);
    run_frame(0, 1'b1);
    wait_idle();

    // 2x2 frame with every weight at full scale: saturation on bright lanes.
    next_vals = reg_vals;
    next_vals[CfgImageWidth]   = 2;
    next_vals[CfgImageHeight]  = 2;
    next_vals[CfgWeightCenter] = '1;
    next_vals[CfgWeightSide]   = '1;
    next_vals[CfgWeightCorner] = '1;
    configure(5'b11111);
    run_frame(0, 1'b1);
    wait_idle();

    // Zero sizes clamp to a single pixel; zero weights give black.
    next_vals = reg_vals;
    next_vals[CfgImageWidth]   = 0;
    next_vals[CfgImageHeight]  = 0;
    next_vals[CfgWeightCenter] = 0;
    next_vals[CfgWeightSide]   = 0;
    next_vals[CfgWeightCorner] = 0;
    configure(5'b11111);
    run_frame(0, 1'b1);
    wait_idle();

    // Back-pressure: a long sink hold with a gapless source fills the
    // output queue and must stall the input channel.
    next_vals = reg_vals;
    next_vals[CfgImageWidth]   = 16;
    next_vals[CfgImageHeight]  = 6;
    next_vals[CfgWeightCenter] = ResetCenter;
    next_vals[CfgWeightSide]   = ResetSide;
    next_vals[CfgWeightCorner] = ResetCorner;
    configure(5'b11111);
    src_gap_max   = 0;
    sink_hold_req = 1'b1;
    run_frame(0, 1'b0);
    wait_idle();

    // Random frames: mostly small images, random kernels and pacing.
    random_start = items_sent;
    while (items_sent - random_start < RandomItems) begin
      src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : MaxGap;
      sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MaxGap;
      next_vals = reg_vals;
      sel = 5'($urandom_range(0, 31));
      if (sel[CfgImageWidth]) begin
        case ($urandom_range(0, 19))
          0:       next_vals[CfgImageWidth] = 0;
          1: begin
            next_vals[CfgImageWidth]  = WeightW'($urandom_range(13, 48));
            next_vals[CfgImageHeight] = WeightW'($urandom_range(1, 2));
            sel[CfgImageHeight] = 1'b1;
          end
          default: next_vals[CfgImageWidth] = WeightW'($urandom_range(1, 12));
        endcase
      end
      if (sel[CfgImageHeight] && next_vals[CfgImageWidth] <= 12) begin
        next_vals[CfgImageHeight] = ($urandom_range(0, 19) == 0) ? '0 :
                                    WeightW'($urandom_range(1, 8));
      end
      // keep wide rows short so most items go to small frames
      if (clamp_size(next_vals[CfgImageWidth][SizeW-1:0], MaxWidth) > 12 &&
          clamp_size(next_vals[CfgImageHeight][SizeW-1:0], MaxHeight) > 2) begin
        next_vals[CfgImageHeight] = 2;
        sel[CfgImageHeight] = 1'b1;
      end
      if (sel[CfgWeightCenter]) next_vals[CfgWeightCenter] = random_weight();
      if (sel[CfgWeightSide]) next_vals[CfgWeightSide] = random_weight();
      if (sel[CfgWeightCorner]) next_vals[CfgWeightCorner] = random_weight();
      configure(sel);

      w = clamp_size(reg_vals[CfgImageWidth][SizeW-1:0], MaxWidth);
      h = clamp_size(reg_vals[CfgImageHeight][SizeW-1:0], MaxHeight);
      frame_len = w * h + w + 1;
      if ($urandom_range(0, 5) == 0) begin
        // Cut the frame, retune only the height, then let the raster run on.
        // Width stays put so no line store entry is read before it is written.
        run_frame($urandom_range(1, frame_len - 1), 1'b0);
        wait_idle();
        next_vals = reg_vals;
        next_vals[CfgImageHeight] = WeightW'($urandom_range(0, 8));
        configure(5'b00010);
        run_frame(0, 1'b0);
      end else begin
        run_frame(0, 1'b0);
      end
      wait_idle();
    end

    // Final drain with a bound of its own; leftovers count as failures.
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < EndWaitLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items in %0d frames with %0d register writes; %0d pixels checked.",
             items_sent, frames_done, reg_writes, results_checked);
    $display("Sizes from 1x1 up to 48 wide, zero sizes, weights 0..4095, pads in and past the image.");
    if (pending != 0) begin
      $display("%0t: %0d expected pixels never came out", $time, pending);
    end
    if (failures == 0 && pending == 0) begin
      $display("gaussian_blur_3x3_unit test passed");
    end else begin
      $display("gaussian_blur_3x3_unit test failed");
    end
    $finish;
  end

endmodule
